// ===== rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

  // register indexes on the configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAGIC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIVER_MASK   = 2'd1;

  localparam logic [31:0] MAGIC_RESET = 32'h3150_544E;
  localparam logic [15:0] MASK_RESET  = 16'h0001;

  // header layout
  localparam logic [15:0] HDR_BYTES = 16'd32;
  localparam logic [4:0]  HDR_LAST  = 5'd31;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [63:0] frame_timestamp;
    logic [15:0] payload_length;
  } rsd_result_t;

endpackage

// ===== rtl/rsd_parser.sv =====
`timescale 1ns / 1ps

module rsd_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     stream_byte,
  input  logic                           cfg_valid,
  input  logic [rsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           queue_full,
  output logic                           push,
  output rsd_pkg::rsd_result_t           push_data
);
  import rsd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  phase_t      phase;
  logic [4:0]  header_position;
  logic [31:0] magic_word;
  logic [15:0] header_size_word;
  logic [15:0] frame_size_word;
  logic [63:0] time_word;
  logic [15:0] flag_word;
  logic [15:0] bytes_left;
  logic        deliver_current;
  logic [31:0] expected_magic;
  logic [15:0] deliver_flag_mask;

  logic accept;
  logic header_done;
  logic header_bad;
  logic deliver_now;
  logic last_byte;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // header checks, all fields are complete by the final header byte
  assign header_done = (header_position == HDR_LAST);
  assign header_bad  = (magic_word != expected_magic) || (header_size_word != HDR_BYTES);
  assign deliver_now = (flag_word & deliver_flag_mask) != 16'd0;
  assign last_byte   = (bytes_left == 16'd1);

  // result classification for the accepted byte
  always_comb begin
    push                      = 1'b0;
    push_data.kind            = KIND_PAYLOAD;
    push_data.payload_byte    = 8'd0;
    push_data.last_of_frame   = 1'b0;
    push_data.frame_timestamp = time_word;
    push_data.payload_length  = frame_size_word;
    case (phase)
      PH_HEADER: begin
        if (header_done) begin
          if (header_bad) begin
            push           = accept;
            push_data.kind = KIND_ERROR;
          end else if (frame_size_word == 16'd0 && deliver_now) begin
            push                    = accept;
            push_data.kind          = KIND_EMPTY;
            push_data.last_of_frame = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        push                    = accept && deliver_current;
        push_data.payload_byte  = stream_byte;
        push_data.last_of_frame = last_byte;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic    <= MAGIC_RESET;
      deliver_flag_mask <= MASK_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_EXPECTED_MAGIC) begin
        expected_magic <= cfg_data;
      end else if (cfg_index == CFG_DELIVER_MASK) begin
        deliver_flag_mask <= cfg_data[15:0];
      end
    end
  end

  // header collection and payload counting
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_position  <= 5'd0;
      magic_word       <= 32'd0;
      header_size_word <= 16'd0;
      frame_size_word  <= 16'd0;
      time_word        <= 64'd0;
      flag_word        <= 16'd0;
      bytes_left       <= 16'd0;
      deliver_current  <= 1'b0;
    end else if (accept) begin
      case (phase)
        PH_HEADER: begin
          // little-endian field capture
          if (header_position < 5'd4) begin
            magic_word[{header_position[1:0], 3'b000} +: 8] <= stream_byte;
          end else if (header_position < 5'd6) begin
            header_size_word[{header_position[0], 3'b000} +: 8] <= stream_byte;
          end else if (header_position < 5'd8) begin
            frame_size_word[{header_position[0], 3'b000} +: 8] <= stream_byte;
          end else if (header_position >= 5'd16 && header_position < 5'd24) begin
            time_word[{header_position[2:0], 3'b000} +: 8] <= stream_byte;
          end else if (header_position == 5'd26 || header_position == 5'd27) begin
            flag_word[{header_position[0], 3'b000} +: 8] <= stream_byte;
          end
          if (!header_done) begin
            header_position <= header_position + 5'd1;
          end else begin
            header_position <= 5'd0;
            if (header_bad) begin
              phase <= PH_HALT;
            end else begin
              deliver_current <= deliver_now;
              bytes_left      <= frame_size_word;
              if (frame_size_word != 16'd0) begin
                phase <= PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left <= bytes_left - 16'd1;
          if (last_byte) begin
            phase <= PH_HEADER;
          end
        end
        default: begin
          phase <= PH_HALT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rsd_queue.sv =====
`timescale 1ns / 1ps

module rsd_queue #(
  parameter int Depth = rsd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rsd_pkg::rsd_result_t push_data,
  input  logic                 pop,
  output rsd_pkg::rsd_result_t pop_data,
  output logic                 full,
  output logic                 empty
);
  import rsd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rsd_result_t     entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntFull);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/rsd_emit.sv =====
`timescale 1ns / 1ps

module rsd_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  rsd_pkg::rsd_result_t queue_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [7:0]           payload_byte,
  output logic                 last_of_frame,
  output logic [63:0]          frame_timestamp,
  output logic [15:0]          payload_length
);
  import rsd_pkg::*;

  // load the output register when it is free or being drained
  assign pop = !queue_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind            <= queue_data.kind;
      payload_byte    <= queue_data.payload_byte;
      last_of_frame   <= queue_data.last_of_frame;
      frame_timestamp <= queue_data.frame_timestamp;
      payload_length  <= queue_data.payload_length;
    end
  end

endmodule

// ===== rtl/record_stream_deframer.sv =====
`timescale 1ns / 1ps

// Record stream deframer: takes one stream byte per cycle while its result queue has room,
// parses 32-byte little-endian record headers and emits one transaction per delivered
// payload byte, per delivered empty frame, or a single framing error after which all input
// is drained silently until reset. A result is written to the queue on the edge that takes
// its byte, then into the output register once that is free or drained; throughput is one
// byte per cycle, limited only by the Depth-entry result queue, which stalls input when
// full. Config writes are always taken and must only be issued while the block is idle.
module record_stream_deframer #(
  parameter int Depth = rsd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      stream_byte,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [7:0]                      payload_byte,
  output logic                            last_of_frame,
  output logic [63:0]                     frame_timestamp,
  output logic [15:0]                     payload_length
);
  import rsd_pkg::*;

  rsd_result_t push_data;
  rsd_result_t pop_data;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;

  assign cfg_ready = 1'b1;

  // front: header parsing and result classification
  rsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data)
  );

  // result queue between front and back
  rsd_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // back: output register
  rsd_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .queue_empty     (queue_empty),
    .queue_data      (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .last_of_frame   (last_of_frame),
    .frame_timestamp (frame_timestamp),
    .payload_length  (payload_length)
  );

endmodule

// ===== rtl/rsd_checker.sv =====
`timescale 1ns / 1ps

module rsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  payload_byte,
  input logic        last_of_frame,
  input logic [63:0] frame_timestamp,
  input logic [15:0] payload_length
);
  import rsd_pkg::*;

  // a stalled result keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte) &&
      $stable(last_of_frame) && $stable(frame_timestamp) && $stable(payload_length))
    else $error("stalled result changed");

  // empty frame result is marked last and carries no byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> last_of_frame && payload_byte == 8'd0)
    else $error("bad empty frame result");

  // framing error carries no byte and no last mark
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> !last_of_frame && payload_byte == 8'd0)
    else $error("bad framing error result");

  // nothing follows a framing error transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_ERROR |=> !out_valid)
    else $error("result after framing error");

endmodule

bind record_stream_deframer rsd_checker u_rsd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .kind            (kind),
  .payload_byte    (payload_byte),
  .last_of_frame   (last_of_frame),
  .frame_timestamp (frame_timestamp),
  .payload_length  (payload_length)
);

// ===== tb/tb_record_stream_deframer.sv =====
`timescale 1ns / 1ps

module tb_record_stream_deframer;
  import rsd_pkg::*;

  // codes on the configuration port that the block does not implement
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 650;
  localparam int LONG_HOLD     = 150;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } parse_phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             stream_byte = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             kind;
  logic [7:0]             payload_byte;
  logic                   last_of_frame;
  logic [63:0]            frame_timestamp;
  logic [15:0]            payload_length;

  record_stream_deframer i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .stream_byte     (stream_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .last_of_frame   (last_of_frame),
    .frame_timestamp (frame_timestamp),
    .payload_length  (payload_length)
  );

  always #5 clk = ~clk;

  // deframer prediction state
  logic [31:0]  magic_setting;
  logic [15:0]  mask_setting;
  parse_phase_t hdr_phase;
  logic [4:0]   hdr_pos;
  logic [31:0]  hdr_magic;
  logic [15:0]  hdr_size;
  logic [15:0]  hdr_frame_len;
  logic [63:0]  hdr_stamp;
  logic [15:0]  hdr_flags;
  logic [15:0]  payload_left;
  logic         frame_delivered;

  rsd_result_t expected_results[$];
  rsd_result_t head_result;

  // run control shared by the sender and the receiver
  bit idle_on = 1'b1;
  int send_odds = 4;
  int sink_odds = 4;
  int long_hold_cycles = 0;
  int sent_count = 0;
  int fail_count = 0;

  function automatic void reset_deframer_model();
    magic_setting   = MAGIC_RESET;
    mask_setting    = MASK_RESET;
    hdr_phase       = PH_HEADER;
    hdr_pos         = '0;
    hdr_magic       = '0;
    hdr_size        = '0;
    hdr_frame_len   = '0;
    hdr_stamp       = '0;
    hdr_flags       = '0;
    payload_left    = '0;
    frame_delivered = 1'b0;
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [7:0] b,
                                      input logic is_last);
    rsd_result_t r;
    r.kind            = k;
    r.payload_byte    = b;
    r.last_of_frame   = is_last;
    r.frame_timestamp = hdr_stamp;
    r.payload_length  = hdr_frame_len;
    expected_results = {expected_results, r};
  endfunction

  // advance the parser by one accepted byte and queue what it produces
  function automatic void deframe_byte(input logic [7:0] b);
    int p;
    p = int'(hdr_pos);
    case (hdr_phase)
      PH_HEADER: begin
        if (p < 4) hdr_magic[8*p +: 8] = b;
        else if (p < 6) hdr_size[8*(p-4) +: 8] = b;
        else if (p < 8) hdr_frame_len[8*(p-6) +: 8] = b;
        else if (p >= 16 && p < 24) hdr_stamp[8*(p-16) +: 8] = b;
        else if (p == 26 || p == 27) hdr_flags[8*(p-26) +: 8] = b;

        if (hdr_pos != HDR_LAST) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          hdr_pos = '0;
          if (hdr_magic != magic_setting || hdr_size != HDR_BYTES) begin
            hdr_phase = PH_HALTED;
            push_result(KIND_ERROR, 8'h00, 1'b0);
          end else begin
            frame_delivered = (hdr_flags & mask_setting) != 16'h0000;
            payload_left    = hdr_frame_len;
            if (hdr_frame_len == 16'h0000) begin
              if (frame_delivered) push_result(KIND_EMPTY, 8'h00, 1'b1);
            end else begin
              hdr_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left = payload_left - 16'd1;
        if (payload_left == 16'h0000) hdr_phase = PH_HEADER;
        if (frame_delivered) push_result(KIND_PAYLOAD, b, payload_left == 16'h0000);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker: every output transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0d byte %0h",
                 $time, kind, payload_byte);
        fail_count++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("kind", 64'(head_result.kind), 64'(kind));
        check_field("payload_byte", 64'(head_result.payload_byte), 64'(payload_byte));
        check_field("last_of_frame", 64'(head_result.last_of_frame), 64'(last_of_frame));
        check_field("frame_timestamp", head_result.frame_timestamp, frame_timestamp);
        check_field("payload_length", 64'(head_result.payload_length),
                    64'(payload_length));
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (idle_on && sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one stream byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    deframe_byte(b);
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [15:0] size,
                             input logic [15:0] frame_len, input logic [63:0] stamp,
                             input logic [15:0] flags);
    logic [255:0] hdr;
    for (int w = 0; w < 8; w++) hdr[32*w +: 32] = $urandom;
    hdr[31:0]    = magic;
    hdr[47:32]   = size;
    hdr[63:48]   = frame_len;
    hdr[191:128] = stamp;
    hdr[223:208] = flags;
    for (int i = 0; i < 32; i++) send_byte(hdr[8*i +: 8]);
  endtask

  task automatic send_record(input logic [15:0] frame_len, input logic [63:0] stamp,
                             input logic [15:0] flags);
    send_header(magic_setting, HDR_BYTES, frame_len, stamp, flags);
    for (int i = 0; i < int'(frame_len); i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // sender pause until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPECTED_MAGIC: magic_setting = data;
      CFG_DELIVER_MASK:   mask_setting  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] magic, input logic [31:0] mask_data);
    write_register(CFG_EXPECTED_MAGIC, magic);
    write_register(CFG_DELIVER_MASK, mask_data);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 4;
      default: return 8;
    endcase
  endfunction

  // reset register values, payload byte extremes
  task automatic test_reset_values();
    send_header(MAGIC_RESET, HDR_BYTES, 16'd2, 64'h0, 16'h0001);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_record(16'd3, {$urandom, $urandom}, 16'h0001);
    wait_drained();
  endtask

  // all-ones timestamp, empty and skipped frames
  task automatic test_frame_cases();
    send_record(16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_record(16'd0, {$urandom, $urandom}, 16'h0001);
    send_record(16'd0, {$urandom, $urandom}, 16'hFFFE);
    send_record(16'd3, {$urandom, $urandom}, 16'h0003);
    send_record(16'd5, {$urandom, $urandom}, 16'h0002);
    send_record(16'd2, {$urandom, $urandom}, 16'h0001);
    wait_drained();
  endtask

  // register extremes, mask truncation, unused indexes
  task automatic test_register_settings();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_8000);
    send_record(16'd2, {$urandom, $urandom}, 16'h8000);
    send_record(16'd2, {$urandom, $urandom}, 16'h7FFF);
    wait_drained();

    apply_settings(32'h0000_0000, 32'h0000_0000);
    send_record(16'd2, {$urandom, $urandom}, 16'hFFFF);
    send_record(16'd0, {$urandom, $urandom}, 16'hFFFF);
    wait_drained();

    write_register(CFG_DELIVER_MASK, 32'h0000_FFFF);
    write_register(CFG_UNUSED_2, $urandom);
    write_register(CFG_UNUSED_3, $urandom);
    cfg_valid <= 1'b0;
    send_record(16'd2, {$urandom, $urandom}, 16'h0100);
    send_record(16'd0, {$urandom, $urandom}, 16'h0400);
    wait_drained();
  endtask

  // receiver holds off long enough to back the block up into its input
  task automatic test_backpressure();
    apply_settings(MAGIC_RESET, 32'h0000_00FF);
    idle_on = 1'b0;
    long_hold_cycles = LONG_HOLD;
    send_record(16'd80, {$urandom, $urandom}, 16'h0010);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // well-formed records with random content, settings changed between phases
  task automatic test_random_records();
    int start_count;
    int recs;
    logic [15:0] len;
    logic [15:0] flags;
    logic [15:0] mask;
    start_count = sent_count;
    recs = 0;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      if (sent_count - start_count > RANDOM_ITEMS - 300) idle_on = 1'b0;
      if (recs % 24 == 23) begin
        wait_drained();
        case ($urandom_range(0, 4))
          0: mask = 16'hFFFF;
          1: mask = 16'h0000;
          2: mask = 16'h0001 << $urandom_range(0, 15);
          default: mask = 16'($urandom);
        endcase
        apply_settings($urandom, {16'($urandom), mask});
      end
      send_odds = pick_odds();
      sink_odds = pick_odds();
      case ($urandom_range(0, 9))
        0: len = 16'd0;
        8, 9: len = 16'($urandom_range(25, 200));
        default: len = 16'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 4))
        0: flags = ~mask_setting;
        1: flags = mask_setting;
        default: flags = 16'($urandom);
      endcase
      send_record(len, {$urandom, $urandom}, flags);
      recs++;
    end
    wait_drained();
  endtask

  // long delivered frame, the byte count borrows across its low byte
  task automatic test_longest_frame();
    idle_on = 1'b0;
    apply_settings(magic_setting, 32'h0000_FFFF);
    send_record(16'd300, {$urandom, $urandom}, 16'($urandom_range(1, 65535)));
    wait_drained();
  endtask

  // bad header halts the parser; everything after is dropped
  task automatic test_framing_error();
    logic [31:0] magic;
    logic [15:0] size;
    magic = magic_setting;
    size  = HDR_BYTES;
    case ($urandom_range(0, 2))
      0: magic = magic_setting ^ (32'h1 << $urandom_range(0, 31));
      1: size = HDR_BYTES ^ 16'($urandom_range(1, 65535));
      default: begin
        magic = ~magic_setting;
        size  = 16'd0;
      end
    endcase
    send_header(magic, size, 16'($urandom), {$urandom, $urandom}, 16'hFFFF);
    send_record(16'd4, {$urandom, $urandom}, 16'hFFFF);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    reset_deframer_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_frame_cases();
    test_register_settings();
    test_backpressure();
    test_random_records();
    test_longest_frame();
    test_framing_error();
    if (fail_count == 0) begin
      $display("record_stream_deframer regression: pass");
    end else begin
      $display("record_stream_deframer regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(20_000_000);
    $display("%0t ns: timeout, %0d results still expected", $time, expected_results.size());
    $display("record_stream_deframer regression: fail");
    $finish;
  end

endmodule
